// ===== sv/hsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_pkg
// Shared constants and types of the HSV saturation / brightness set block.
// ----------------------------------------------------------------------------
package hsb_pkg;

    // channel and hue constants
    localparam int unsigned CH_MAX     = 255;
    localparam int unsigned DEG_SECTOR = 60;
    localparam int unsigned HUE_LIMIT  = 359;
    localparam int unsigned SECTORS    = 6;
    localparam int unsigned HUE_DEN    = DEG_SECTOR * CH_MAX;   // 15300

    // reciprocals for the constant divisions of the inverse conversion:
    // x / 255   = (x * RECIP_CH)  >> RECIP_CH_SH,  exact for x <= 65025
    // x / 15300 = (x * RECIP_DEN) >> RECIP_DEN_SH, exact for x <= 255 * 15300
    localparam int unsigned RECIP_CH     = 65794;
    localparam int unsigned RECIP_CH_SH  = 24;
    localparam int unsigned RECIP_DEN    = 4491470;
    localparam int unsigned RECIP_DEN_SH = 36;

    // register indexes (byte address = 4 * index)
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_VALUE = 1'b1;

    // adjust_mode codes
    localparam logic MODE_SAT = 1'b0;
    localparam logic MODE_VAL = 1'b1;

    // hue sector base for the winning channel
    localparam logic [2:0] BASE_RED   = 3'd0;
    localparam logic [2:0] BASE_GREEN = 3'd2;
    localparam logic [2:0] BASE_BLUE  = 3'd4;

    // pipeline control handed to a divider
    typedef struct packed {
        logic en;       // whole pipeline advances
        logic valid;    // item present at the divider input
    } hsb_ctrl_t;

endpackage

// ===== sv/hsb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_div
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one valid bit and one sideband word.
// ----------------------------------------------------------------------------
module hsb_div #(
    parameter int LANES = 2,
    parameter int NW    = 17,
    parameter int DW    = 8,
    parameter int SW    = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hsb_pkg::hsb_ctrl_t   ctrl,
    input  logic [NW-1:0]        dividend [LANES],
    input  logic [DW-1:0]        divisor  [LANES],
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic [NW-1:0]        quotient [LANES],
    output logic [SW-1:0]        side_out
);

    logic          vld_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic [DW-1:0] rem_reg  [NW][LANES];
    logic [NW-1:0] acc_reg  [NW][LANES];
    logic [DW-1:0] dvs_reg  [NW][LANES];

    genvar k, l;
    for (k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [SW-1:0] s_in;
        logic [DW-1:0] r_in [LANES];
        logic [NW-1:0] a_in [LANES];
        logic [DW-1:0] d_in [LANES];

        // stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign v_in = ctrl.valid;
            assign s_in = side_in;
            for (l = 0; l < LANES; l++) begin : g_in
                assign r_in[l] = '0;
                assign a_in[l] = dividend[l];
                assign d_in[l] = divisor[l];
            end
        end else begin : g_next
            assign v_in = vld_reg[k-1];
            assign s_in = side_reg[k-1];
            for (l = 0; l < LANES; l++) begin : g_in
                assign r_in[l] = rem_reg[k-1][l];
                assign a_in[l] = acc_reg[k-1][l];
                assign d_in[l] = dvs_reg[k-1][l];
            end
        end

        // one compare and subtract per lane
        for (l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] rem_next;
            assign trial    = {r_in[l], a_in[l][NW-1]};
            assign ge       = (trial >= {1'b0, d_in[l]});
            assign rem_next = ge ? DW'(trial - {1'b0, d_in[l]}) : trial[DW-1:0];

            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    rem_reg[k][l] <= rem_next;
                    acc_reg[k][l] <= {a_in[l][NW-2:0], ge};
                    dvs_reg[k][l] <= d_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ctrl.en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign side_out  = side_reg[NW-1];
    for (l = 0; l < LANES; l++) begin : g_out
        assign quotient[l] = acc_reg[NW-1][l];
    end

endmodule

// ===== sv/hsv_saturation_brightness_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_saturation_brightness_set
// RGB pixel to integer HSV, saturation or value replaced, back to RGB.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one RGB pixel per transaction, m_tdata the adjusted
//   pixel; each input transaction gives exactly one output transaction.
//   The APB port sets adjust_mode (0x0) and adjust_value (0x4); write them
//   only while no pixel is in flight.
//   The pipeline has 24 register stages: the accepting edge loads the first
//   one, and the last one drives m_tdata. The stages are two input stages,
//   a 17-stage divider for saturation and hue, three stages for sector
//   split and products, one stage of reciprocal products for the constant
//   divisions of the inverse conversion, and the output register.
//   It takes one pixel per cycle unless stalled. The pipeline advances as a whole
//   whenever the output register is empty or being taken, so s_tready
//   follows m_tready; a stall freezes every stage and loses nothing.
//   Reset clears all valid bits and sets adjust_mode to 0 and adjust_value
//   to 255.
// ----------------------------------------------------------------------------
module hsv_saturation_brightness_set (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel: [7:0] in_red, [15:8] in_green, [23:16] in_blue
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // output pixel: [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       mode_reg;
    logic [7:0] adj_reg;
    logic       adv;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hsb_pkg::MODE_SAT;
            adj_reg  <= 8'd255;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                hsb_pkg::REG_MODE:  mode_reg <= pwdata[0];
                hsb_pkg::REG_VALUE: adj_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            hsb_pkg::REG_MODE:  prdata = {31'd0, mode_reg};
            hsb_pkg::REG_VALUE: prdata = {24'd0, adj_reg};
            default:            prdata = '0;
        endcase
    end

    // global advance
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: max, min, winning channel ----------------
    logic [7:0] in_r, in_g, in_b, hi, lo;
    logic [2:0] base_next;
    logic signed [8:0] diff_next;
    assign in_r = s_tdata[7:0];
    assign in_g = s_tdata[15:8];
    assign in_b = s_tdata[23:16];

    always_comb begin
        hi = in_r;
        lo = in_r;
        if (in_g > hi) hi = in_g;
        if (in_b > hi) hi = in_b;
        if (in_g < lo) lo = in_g;
        if (in_b < lo) lo = in_b;
        if (in_b == hi) begin
            base_next = hsb_pkg::BASE_BLUE;
            diff_next = $signed({1'b0, in_r}) - $signed({1'b0, in_g});
        end else if (in_g == hi) begin
            base_next = hsb_pkg::BASE_GREEN;
            diff_next = $signed({1'b0, in_b}) - $signed({1'b0, in_r});
        end else begin
            base_next = hsb_pkg::BASE_RED;
            diff_next = $signed({1'b0, in_g}) - $signed({1'b0, in_b});
        end
    end

    logic              v1_reg;
    logic [7:0]        max1_reg, d1_reg;
    logic [2:0]        base1_reg;
    logic signed [8:0] diff1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            max1_reg  <= hi;
            d1_reg    <= hi - lo;
            base1_reg <= base_next;
            diff1_reg <= diff_next;
        end
    end

    // ---------------- stage 2: hue numerator, dividends ----------------
    logic [10:0]        bd;
    logic signed [11:0] num_raw;
    logic [10:0]        num;
    assign bd      = 11'(base1_reg * d1_reg);
    assign num_raw = $signed({1'b0, bd}) + 12'(diff1_reg);
    assign num     = (num_raw < 0) ? 11'(num_raw + $signed({1'b0, 11'(d1_reg * 4'd6)}))
                                   : num_raw[10:0];

    logic        v2_reg;
    logic [16:0] hue_dvd_reg, sat_dvd_reg;
    logic [7:0]  d2_reg, max2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hue_dvd_reg <= 17'(num * 6'd60);
            sat_dvd_reg <= {1'b0, 16'(d1_reg * 8'd255)};
            d2_reg      <= d1_reg;
            max2_reg    <= max1_reg;
        end
    end

    // ---------------- divider 1: saturation and hue ----------------
    hsb_pkg::hsb_ctrl_t ctrl1;
    logic [16:0] dvd1 [2];
    logic [7:0]  dvs1 [2];
    logic [16:0] quo1 [2];
    logic        dv1_valid;
    logic [7:0]  dv1_max;

    assign ctrl1.en    = adv;
    assign ctrl1.valid = v2_reg;
    assign dvd1[0]     = sat_dvd_reg;
    assign dvs1[0]     = max2_reg;
    assign dvd1[1]     = hue_dvd_reg;
    assign dvs1[1]     = d2_reg;

    hsb_div #(.LANES(2), .NW(17), .DW(8), .SW(8)) u_div_hs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl1),
        .dividend  (dvd1),
        .divisor   (dvs1),
        .side_in   (max2_reg),
        .out_valid (dv1_valid),
        .quotient  (quo1),
        .side_out  (dv1_max)
    );

    // ---------------- stage 3: replace, sector split ----------------
    logic [7:0] s_raw, s_sel, v_sel;
    logic [8:0] hue, hsub;
    logic [2:0] sec_next;

    always_comb begin
        s_raw = (dv1_max == 8'd0) ? 8'd0 : quo1[0][7:0];
        if (s_raw == 8'd0 || quo1[1] > 17'(hsb_pkg::HUE_LIMIT)) begin
            hue = 9'd0;
        end else begin
            hue = quo1[1][8:0];
        end
        if (mode_reg == hsb_pkg::MODE_SAT) begin
            s_sel = adj_reg;
            v_sel = dv1_max;
        end else begin
            s_sel = s_raw;
            v_sel = adj_reg;
        end
        if      (hue >= 9'd300) begin sec_next = 3'd5; hsub = 9'd300; end
        else if (hue >= 9'd240) begin sec_next = 3'd4; hsub = 9'd240; end
        else if (hue >= 9'd180) begin sec_next = 3'd3; hsub = 9'd180; end
        else if (hue >= 9'd120) begin sec_next = 3'd2; hsub = 9'd120; end
        else if (hue >= 9'd60)  begin sec_next = 3'd1; hsub = 9'd60;  end
        else                    begin sec_next = 3'd0; hsub = 9'd0;   end
    end

    logic       v3_reg;
    logic [2:0] sec3_reg;
    logic [5:0] m3_reg;
    logic [7:0] s3_reg, val3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= dv1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sec3_reg <= sec_next;
            m3_reg   <= 6'(hue - hsub);
            s3_reg   <= s_sel;
            val3_reg <= v_sel;
        end
    end

    // ---------------- stage 4: first products ----------------
    logic        v4_reg;
    logic [2:0]  sec4_reg;
    logic [7:0]  val4_reg;
    logic [13:0] ms4_reg, ns4_reg;
    logic [15:0] ps4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
            ms4_reg  <= 14'(m3_reg * s3_reg);
            ns4_reg  <= 14'((6'd60 - m3_reg) * s3_reg);
            ps4_reg  <= 16'(val3_reg * (8'd255 - s3_reg));
        end
    end

    // ---------------- stage 5: second products ----------------
    logic        v5_reg;
    logic [10:0] side5_reg;
    logic [15:0] ps5_reg;
    logic [21:0] qa5_reg, ta5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side5_reg <= {sec4_reg, val4_reg};
            ps5_reg   <= ps4_reg;
            qa5_reg   <= 22'(val4_reg * (14'(hsb_pkg::HUE_DEN) - ms4_reg));
            ta5_reg   <= 22'(val4_reg * (14'(hsb_pkg::HUE_DEN) - ns4_reg));
        end
    end

    // ---------------- stage 6: reciprocal products for p, q, t ----------------
    logic        v6_reg;
    logic [10:0] side6_reg;
    logic [32:0] pm6_reg;
    logic [44:0] qm6_reg, tm6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side6_reg <= side5_reg;
            pm6_reg   <= 33'(ps5_reg * 17'(hsb_pkg::RECIP_CH));
            qm6_reg   <= 45'(qa5_reg * 23'(hsb_pkg::RECIP_DEN));
            tm6_reg   <= 45'(ta5_reg * 23'(hsb_pkg::RECIP_DEN));
        end
    end

    // ---------------- output: sector select ----------------
    logic [7:0] pv, qv, tv, vv;
    logic [23:0] pix_next;
    assign pv = pm6_reg[hsb_pkg::RECIP_CH_SH +: 8];
    assign qv = qm6_reg[hsb_pkg::RECIP_DEN_SH +: 8];
    assign tv = tm6_reg[hsb_pkg::RECIP_DEN_SH +: 8];
    assign vv = side6_reg[7:0];

    always_comb begin
        case (side6_reg[10:8])
            3'd0:    pix_next = {pv, tv, vv};
            3'd1:    pix_next = {pv, vv, qv};
            3'd2:    pix_next = {tv, vv, pv};
            3'd3:    pix_next = {vv, qv, pv};
            3'd4:    pix_next = {vv, pv, tv};
            default: pix_next = {qv, pv, vv};
        endcase
    end

    logic [23:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= pix_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/hsb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_checker
// Port-level checks of the HSV saturation / brightness set block.
// ----------------------------------------------------------------------------
module hsb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        pready
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed under stall");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // input side moves exactly when the output register can move
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output state");

    // configuration port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind hsv_saturation_brightness_set hsb_checker u_hsb_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HSV saturation / brightness set block.
// Pixels go in over the input stream with random gaps, and the output stream
// applies random backpressure. Each accepted pixel is converted to HSV, the
// configured channel is replaced, and the pixel is converted back in the
// bench. Outputs are compared in order against that prediction. Both register
// settings are swept between phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PIPE_LAT  = 24;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench copy of the registers
    logic        mode_q = hsb_pkg::MODE_SAT;
    logic [7:0]  level_q = 8'd255;

    pixel_t      pending_pixels[$];
    int          errors = 0;
    int          cycles = 0;
    bit          rx_stall_on = 1'b1;

    hsv_saturation_brightness_set u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // forward conversion, channel replacement, inverse conversion
    function automatic pixel_t adjusted_pixel(pixel_t px, logic md, logic [7:0] lvl);
        int r, g, b, hi, lo, d, num, hue, sat, val, sec, m, p, q, t;
        pixel_t o;
        r = int'(px.red); g = int'(px.green); b = int'(px.blue);
        hi = r; lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        val = hi;
        d = hi - lo;
        sat = (hi == 0) ? 0 : (d * 255) / hi;
        hue = 0;
        if (sat != 0) begin
            // blue beats green beats red on ties
            if (b == hi) num = 4 * d + (r - g);
            else if (g == hi) num = 2 * d + (b - r);
            else num = g - b;
            if (num < 0) num += 6 * d;
            hue = (num * 60) / d;
            if (hue > 359) hue = 0;
        end
        if (md == hsb_pkg::MODE_SAT) sat = int'(lvl);
        else val = int'(lvl);
        sec = hue / 60;
        m = hue % 60;
        p = (val * (255 - sat)) / 255;
        q = (val * (15300 - m * sat)) / 15300;
        t = (val * (15300 - (60 - m) * sat)) / 15300;
        case (sec)
            0: begin o.red = 8'(val); o.green = 8'(t); o.blue = 8'(p); end
            1: begin o.red = 8'(q); o.green = 8'(val); o.blue = 8'(p); end
            2: begin o.red = 8'(p); o.green = 8'(val); o.blue = 8'(t); end
            3: begin o.red = 8'(p); o.green = 8'(q); o.blue = 8'(val); end
            4: begin o.red = 8'(t); o.green = 8'(p); o.blue = 8'(val); end
            default: begin o.red = 8'(val); o.green = 8'(p); o.blue = 8'(q); end
        endcase
        return o;
    endfunction

    // output side: random stall, compare each transaction
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, got);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
                    errors++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
                    errors++;
                end
            end
        end
    end

    // ready pattern: before each output, m_tready may drop for a random wait
    initial begin
        int w;
        forever begin
            w = rx_stall_on ? $urandom_range(0, 7) : 0;
            if ($urandom_range(0, 3) == 0) w = 0;
            m_tready <= (w == 0);
            while (w > 0) begin
                @(posedge aclk);
                w--;
                m_tready <= (w == 0);
            end
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // one input transaction after a random gap; valid stays up for the next
    task automatic send_pixel(pixel_t px, bit gaps = 1'b1);
        int w;
        w = gaps ? $urandom_range(0, 7) : 0;
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(adjusted_pixel(px, mode_q, level_q));
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    // APB write: setup phase, access phase, then idle
    task automatic write_reg(logic idx, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == hsb_pkg::REG_MODE) mode_q = data[0];
        else level_q = data[7:0];
        @(posedge aclk);
    endtask

    task automatic set_adjust(logic md, logic [7:0] lvl);
        drain_pipe();
        write_reg(hsb_pkg::REG_MODE, {31'd0, md});
        write_reg(hsb_pkg::REG_VALUE, {24'd0, lvl});
    endtask

    // extremes, ties between channels, hue wrap, gray and black
    task automatic test_directed();
        pixel_t list[$];
        list = '{ 24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
                  24'hFF0000, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0100FF,
                  24'hFF0001, 24'h010101, 24'h5555AA, 24'hAA55AA, 24'h00FE01,
                  24'h7F80FF, 24'h010001, 24'hFE00FF, 24'h000100, 24'h00AA55 };
        foreach (list[i]) send_pixel(list[i]);
    endtask

    task automatic test_random(int n);
        pixel_t px;
        repeat (n) begin
            px = pixel_t'(24'($urandom));
            if ($urandom_range(0, 7) == 0) px.green = px.red;   // ties
            if ($urandom_range(0, 7) == 0) px.blue = px.red;
            send_pixel(px, $urandom_range(0, 3) != 0);
        end
    endtask

    // back-to-back burst with the output never stalled
    task automatic test_full_rate(int n);
        rx_stall_on = 1'b0;
        drain_pipe();
        repeat (n) send_pixel(pixel_t'(24'($urandom)), 1'b0);
        rx_stall_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_adjust(hsb_pkg::MODE_SAT, 8'd0);
        test_directed();
        set_adjust(hsb_pkg::MODE_VAL, 8'd0);
        test_directed();
        set_adjust(hsb_pkg::MODE_VAL, 8'd255);
        test_random(300);
        set_adjust(hsb_pkg::MODE_SAT, 8'd255);
        test_random(300);
        set_adjust(hsb_pkg::MODE_SAT, 8'd128);
        test_full_rate(200);
        set_adjust(hsb_pkg::MODE_VAL, 8'd77);
        test_random(300);
        set_adjust(hsb_pkg::MODE_SAT, 8'($urandom_range(1, 254)));
        test_random(250);
        drain_pipe();
        write_reg(hsb_pkg::REG_MODE, 32'hFFFF_FFFE);   // high bits dropped
        write_reg(hsb_pkg::REG_VALUE, 32'hABCD_EF13);
        test_random(250);
        drain_pipe();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
